[rtl/vdedup_pkg.sv]
// shared types, sizes and helpers for the exact-match vertex deduplicator
package vdedup_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 256;
   localparam int VIDX_W      = 10;
   localparam int RSP_DATA_W  = 16;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic              table_full;
      logic              is_new;
      logic [VIDX_W-1:0] vertex_index;
   } res_type;

   // low bits of a table index, zero-extended when the table is narrow
   function automatic logic [VIDX_W-1:0] to_vidx(input logic [IDX_W-1:0] idx);
      logic [VIDX_W+IDX_W-1:0] wide;
      wide = {{VIDX_W{1'b0}}, idx};
      return wide[VIDX_W-1:0];
   endfunction

endpackage

[rtl/vdedup_key_ram.sv]
// key table memory: one write port, one registered read port
module vdedup_key_ram (
   input  logic                      clock,
   input  vdedup_pkg::mem_req_type   mem_req,
   output logic [vdedup_pkg::KEY_W-1:0] rd_data
);
   import vdedup_pkg::*;

   logic [KEY_W-1:0] key_mem_ff [TABLE_DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         key_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= key_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/vdedup_walk.sv]
// lookup sequencer: walks stored keys through one comparator, appends on a miss unless the table is full
module vdedup_walk (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         first_of_mesh,
   input  logic [vdedup_pkg::KEY_W-1:0] key,
   output logic                         idle,
   output logic                         res_vld,
   input  logic                         res_rdy,
   output vdedup_pkg::res_type          res,
   output vdedup_pkg::mem_req_type      mem_req,
   input  logic [vdedup_pkg::KEY_W-1:0] rd_data
);
   import vdedup_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [KEY_W-1:0] key_ff, key_in;
   res_type          res_ff, res_in;
   logic             hit;

   // one comparator, fed one stored key per cycle
   assign hit = pend_ff && (rd_data == key_ff);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      scan_in         = scan_ff;
      pend_in         = 1'b0;
      pidx_in         = pidx_ff;
      key_in          = key_ff;
      res_in          = res_ff;
      mem_req         = '0;
      mem_req.rd_addr = scan_ff[IDX_W-1:0];
      mem_req.wr_addr = count_ff[IDX_W-1:0];
      mem_req.wr_data = key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = key;
               scan_in  = '0;
               state_in = ST_SCAN;
               if (first_of_mesh) begin
                  count_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.vertex_index = to_vidx(pidx_ff);
               res_in.is_new       = 1'b0;
               res_in.table_full   = 1'b0;
               state_in            = ST_RESP;
            end else if (scan_ff < count_ff) begin
               mem_req.rd_en = 1'b1;
               scan_in       = scan_ff + CNT_W'(1);
               pend_in       = 1'b1;
               pidx_in       = scan_ff[IDX_W-1:0];
            end else if (!pend_ff) begin
               // every stored key compared without a hit
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  res_in.vertex_index = '0;
                  res_in.is_new       = 1'b0;
                  res_in.table_full   = 1'b1;
               end else begin
                  mem_req.wr_en       = 1'b1;
                  count_in            = count_ff + CNT_W'(1);
                  res_in.vertex_index = to_vidx(count_ff[IDX_W-1:0]);
                  res_in.is_new       = 1'b1;
                  res_in.table_full   = 1'b0;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_rdy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      scan_ff <= scan_in;
      pidx_ff <= pidx_in;
      key_ff  <= key_in;
      res_ff  <= res_in;
   end

   assign idle    = (state_ff == ST_IDLE);
   assign res_vld = (state_ff == ST_RESP);
   assign res     = res_ff;

endmodule

[rtl/exact_match_vertex_dedup_top.sv]
// top level of the exact-match vertex deduplicator
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata: 8 x 32-bit key words, tuser: first_of_mesh
//  rsp     | out | rsp_tvalid/tready  | tdata: vertex_index, is_new, table_full
//
// a miss compares every stored entry before its result, and a hit on entry i stops the
// scan at that entry; during a scan the single 256-bit comparator sees one stored key
// per cycle from the key memory read port.
// req_tready is high only between vertices.
// reset empties the table (entry count to zero); no clearing pass is needed.
// a stalled rsp holds its result in the output register, and the next vertex
// is taken while it waits; the sequencer blocks only once a second result is ready.
module exact_match_vertex_dedup_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
   input  logic [vdedup_pkg::KEY_W-1:0]           req_tdata,
   // first_of_mesh
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // vertex_index[9:0], is_new, table_full, zero pad
   output logic [vdedup_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import vdedup_pkg::*;

   mem_req_type      mem_req;
   logic [KEY_W-1:0] rd_data;
   logic             idle;
   logic             res_vld;
   logic             res_rdy;
   res_type          res;
   logic             rsp_valid_ff;
   res_type          rsp_data_ff;

   assign req_tready = idle;

   vdedup_walk u_walk (
      .clock         (clock),
      .reset         (reset),
      .start         (req_tvalid && req_tready),
      .first_of_mesh (req_tuser),
      .key           (req_tdata),
      .idle          (idle),
      .res_vld       (res_vld),
      .res_rdy       (res_rdy),
      .res           (res),
      .mem_req       (mem_req),
      .rd_data       (rd_data)
   );

   vdedup_key_ram u_key_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // output register lets the sequencer go on while one stalled result waits on rsp
   assign res_rdy = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_rdy) begin
         rsp_valid_ff <= res_vld;
      end
      if (res_rdy && res_vld) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VIDX_W - 2){1'b0}},
                        rsp_data_ff.table_full, rsp_data_ff.is_new,
                        rsp_data_ff.vertex_index};

   a_no_back_to_back : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a lookup is in progress");

   a_new_or_full : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_data_ff.is_new && rsp_data_ff.table_full))
      else $error("result both appended and full");

   a_full_index_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.table_full) |-> (rsp_data_ff.vertex_index == '0))
      else $error("full result with nonzero index");

   a_handoff : assert property (@(posedge clock) disable iff (reset)
      (res_vld && res_rdy) |=> (rsp_tvalid && !res_vld))
      else $error("result lost or repeated at output register");

endmodule

[bench/tb_top.sv]
// self-checking bench for the exact-match vertex deduplicator
`timescale 1ns / 1ps

module tb_top;
   import vdedup_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 560;
   localparam int STALL_CYCLES   = 400;

   typedef struct {
      bit               first;
      logic [KEY_W-1:0] key;
      bit               typed;
      res_type          res;
   } vertex_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [KEY_W-1:0]      req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predictor state: distinct keys of the current mesh in order of first arrival
   logic [KEY_W-1:0] seen_keys [TABLE_DEPTH];
   int unsigned      seen_count;
   res_type          pending_lookups [$];
   vertex_row_type   vertex_rows [$];

   int               idle_mode;
   int unsigned      error_count;
   int unsigned      rsp_seen;
   int unsigned      quiet_cycles;

   exact_match_vertex_dedup_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic res_type result_of(input int unsigned idx, input bit fresh,
                                         input bit full);
      res_type r;
      r.vertex_index = VIDX_W'(idx);
      r.is_new       = fresh;
      r.table_full   = full;
      return r;
   endfunction

   // pos_x lands in the lowest word, norm_z in the highest
   function automatic logic [KEY_W-1:0] key_of(
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [31:0] u, input logic [31:0] v,
      input logic [31:0] nx, input logic [31:0] ny, input logic [31:0] nz);
      return {nz, ny, nx, v, u, pz, py, px};
   endfunction

   function automatic logic [KEY_W-1:0] splat_key(input logic [31:0] w);
      return {8{w}};
   endfunction

   function automatic res_type lookup_vertex(input bit first, input logic [KEY_W-1:0] key);
      res_type r;
      if (first)
         seen_count = 0;
      for (int i = 0; i < seen_count; i++)
         if (seen_keys[i] == key)
            return result_of(i, 1'b0, 1'b0);
      // miss on a full table stores nothing
      if (seen_count >= TABLE_DEPTH)
         return result_of(0, 1'b0, 1'b1);
      seen_keys[seen_count] = key;
      r = result_of(seen_count, 1'b1, 1'b0);
      seen_count++;
      return r;
   endfunction

   function automatic logic [31:0] float_word();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'h7fc0_0000;
         4: return 32'h3f80_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      return key_of(float_word(), float_word(), float_word(), float_word(),
                    float_word(), float_word(), float_word(), float_word());
   endfunction

   function automatic int tx_idle_pct();
      case (idle_mode)
         0: return 11;
         1: return 47;
         default: return 0;
      endcase
   endfunction

   function automatic int rx_idle_pct();
      case (idle_mode)
         0: return 47;
         1: return 11;
         default: return 0;
      endcase
   endfunction

   task automatic add_row(input bit first, input logic [KEY_W-1:0] key, input bit typed,
                          input res_type res);
      vertex_row_type row;
      row.first = first;
      row.key   = key;
      row.typed = typed;
      row.res   = res;
      vertex_rows.insert(vertex_rows.size(), row);
   endtask

   // offer one vertex and record the expected lookup once the transaction lands
   task automatic send_vertex(input bit first, input logic [KEY_W-1:0] key, input bit typed,
                              input res_type typed_res);
      res_type predicted;
      while ($urandom_range(99) < tx_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = lookup_vertex(first, key);
      pending_lookups.insert(pending_lookups.size(), typed ? typed_res : predicted);
   endtask

   task automatic report_mismatch(input string what, input res_type want,
                                  input logic [RSP_DATA_W-1:0] got);
      error_count++;
      if (error_count <= 10)
         $display({"mismatch (%s) at %0t: expected idx=%0d new=%0b full=%0b, ",
                   "got idx=%0d new=%0b full=%0b pad=%h"},
                  what, $realtime, want.vertex_index, want.is_new, want.table_full,
                  got[VIDX_W-1:0], got[VIDX_W], got[VIDX_W+1], got[RSP_DATA_W-1:VIDX_W+2]);
   endtask

   // result side: random backpressure plus one long hold-off
   initial begin
      res_type                 want;
      logic [RSP_DATA_W-1:0]   got;
      bit                      stall_done;
      stall_done = 1'b0;
      rsp_tready = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (!stall_done && rsp_seen >= 40) begin
            stall_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct());
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            rsp_seen++;
            if (pending_lookups.size() == 0) begin
               report_mismatch("unexpected result", '0, got);
            end else begin
               want = pending_lookups.pop_front();
               if (got[VIDX_W-1:0] !== want.vertex_index || got[VIDX_W] !== want.is_new ||
                   got[VIDX_W+1] !== want.table_full || got[RSP_DATA_W-1:VIDX_W+2] !== '0)
                  report_mismatch("field", want, got);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** exact_match_vertex_dedup_top: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] mesh_keys [$];
      logic [KEY_W-1:0] key;
      bit               first;
      int               pick;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      seen_count  = 0;
      idle_mode   = 0;
      error_count = 0;
      rsp_seen    = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table after reset, signed zeros, NaN payloads, mesh restart
      add_row(1'b0, splat_key(32'h0000_0000), 1'b1, result_of(0, 1'b1, 1'b0));
      add_row(1'b0, splat_key(32'h0000_0000), 1'b1, result_of(0, 1'b0, 1'b0));
      add_row(1'b0, key_of(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              result_of(1, 1'b1, 1'b0));
      add_row(1'b0, splat_key(32'hffff_ffff), 1'b1, result_of(2, 1'b1, 1'b0));
      add_row(1'b0, splat_key(32'h0000_0000), 1'b1, result_of(0, 1'b0, 1'b0));
      add_row(1'b0, key_of(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
              result_of(1, 1'b0, 1'b0));
      for (int w = 1; w < 8; w++) begin
         key = '0;
         key[w*32 + 31] = 1'b1;
         add_row(1'b0, key, 1'b0, '0);
      end
      add_row(1'b0, splat_key(32'h7fc0_0000), 1'b0, '0);
      add_row(1'b0, splat_key(32'h7fc0_0001), 1'b0, '0);
      add_row(1'b0, splat_key(32'h7fc0_0000), 1'b0, '0);
      add_row(1'b1, splat_key(32'hffff_ffff), 1'b1, result_of(0, 1'b1, 1'b0));
      add_row(1'b0, splat_key(32'h0000_0000), 1'b1, result_of(1, 1'b1, 1'b0));
      add_row(1'b0, splat_key(32'hffff_ffff), 1'b1, result_of(0, 1'b0, 1'b0));
      add_row(1'b1, splat_key(32'hffff_ffff), 1'b1, result_of(0, 1'b1, 1'b0));

      foreach (vertex_rows[r])
         send_vertex(vertex_rows[r].first, vertex_rows[r].key, vertex_rows[r].typed,
                     vertex_rows[r].res);
      mesh_keys.insert(mesh_keys.size(), splat_key(32'hffff_ffff));

      // random meshes: repeats, one-bit near misses and fresh vertices
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         idle_mode = (k < 187) ? 0 : (k < 374) ? 1 : 2;
         first = ($urandom_range(15) == 0) || (mesh_keys.size() >= 64);
         pick  = $urandom_range(99);
         if (pick < 40 && mesh_keys.size() > 0) begin
            key = mesh_keys[$urandom_range(mesh_keys.size() - 1)];
         end else if (pick < 55 && mesh_keys.size() > 0) begin
            key = mesh_keys[$urandom_range(mesh_keys.size() - 1)];
            pick = $urandom_range(KEY_W - 1);
            key[pick] = ~key[pick];
         end else begin
            key = random_key();
         end
         if (first)
            mesh_keys.delete();
         mesh_keys.insert(mesh_keys.size(), key);
         send_vertex(first, key, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_lookups.size() != 0)
         @(posedge clock);
      repeat (TABLE_DEPTH + 10) @(posedge clock);

      if (error_count == 0)
         $display("** exact_match_vertex_dedup_top: PASSED **");
      else
         $display("** exact_match_vertex_dedup_top: FAILED **");
      $finish;
   end

endmodule

[sim.f]
rtl/vdedup_pkg.sv
rtl/vdedup_key_ram.sv
rtl/vdedup_walk.sv
rtl/exact_match_vertex_dedup_top.sv
bench/tb_top.sv
